// ===== design/tmv_pkg.sv =====
package tmv_pkg;

  // Command codes carried in the input item
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int ROW_W = 10;
  localparam int CMD_W = 2;
  localparam int ACC_W = 64;

  // Scaled-accumulator split: magnitude clamp, hi/lo split point, quotient cap
  localparam int CM_W    = 49;
  localparam int SPLIT_W = 24;
  localparam int HI_W    = CM_W - SPLIT_W + VAL_W;
  localparam int LO_W    = SPLIT_W + VAL_W;
  localparam int Q_W     = 34;
  localparam int RES_W   = 36;

  localparam logic [ACC_W-1:0] CM_CLAMP = 64'h0001_0000_0000_0000;
  localparam logic [65:0]      Q_CAP    = 66'h2_0000_0000;

  localparam logic signed [VAL_W-1:0] ALPHA_RESET = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN     = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] y_result;
    logic                    saturated;
  } out_item_t;

  typedef logic signed [VAL_W-1:0] cfg_word_t;

endpackage

// ===== design/tmv_chan_if.sv =====
// Valid/ready channel; one transfer when valid and ready are both high
interface tmv_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/transposed_matrix_vector_mac.sv =====
// Transposed matrix-vector multiply-accumulate, y[j] += alpha * dot(A[:,j], x),
// signed Q16.16.
// in_ch  : command 0 writes value into the x store at row_index; command 1
//          multiplies value by stored x[row_index] into the column accumulator;
//          command 2 carries old y and produces one result; command 3 is dropped.
// out_ch : y_result (saturated Q16.16) and saturated, one transfer per finish.
// cfg_ch : alpha (Q16.16); write only while no item is in flight.
// Throughput: one item per cycle while not stalled; the x store is one
// synchronous RAM (one write and one read port), the 32x32 product feeds
// a registered accumulator add; the alpha scaling is a further four-stage pipe.
// Reset: alpha returns to 1.0, accumulator and overflow flag clear, the
// pipeline empties. The x store is not cleared; reading an unwritten row
// gives an undefined product.
// Stall: while a result waits on out_ch and the next finish result has reached
// the last stage, the whole pipeline holds and in_ch.ready is low; otherwise
// input transfers continue while the output waits.
module transposed_matrix_vector_mac #(
  parameter int MAX_ROWS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  tmv_chan_if.sink   in_ch,
  tmv_chan_if.source out_ch,
  tmv_chan_if.sink   cfg_ch
);
  import tmv_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Handshake and address
  logic          advance;
  logic          in_fire;
  logic          in_range;
  logic [AW-1:0] in_addr;

  // Configuration
  cfg_word_t          alpha_r;
  logic [VAL_W-1:0]   alpha_mag_r;
  logic [VAL_W-1:0]   alpha_mag_nxt;

  // x store
  logic [VAL_W-1:0] mem [MAX_ROWS];
  logic [VAL_W-1:0] rd_data_r;

  // Stage 1: read issued
  logic                    s1_col_r, s1_fin_r, s1_hit_r;
  logic signed [VAL_W-1:0] s1_value_r;
  logic signed [VAL_W-1:0] x_op;
  logic signed [ACC_W-1:0] mul_p;

  // Stage 2: product
  logic                    s2_col_r, s2_fin_r;
  logic signed [VAL_W-1:0] s2_y_r;
  logic signed [ACC_W-1:0] s2_prod_r;

  // Accumulator
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W:0]   sum_w;
  logic                    acc_ovf;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        acc_mag;
  logic [CM_W-1:0]         cm_nxt;

  // Stage 3..6: alpha scaling
  logic                    s3_valid_r, s3_neg_r, s3_ovf_r;
  logic signed [VAL_W-1:0] s3_y_r;
  logic [CM_W-1:0]         s3_cm_r;
  logic                    s4_valid_r, s4_neg_r, s4_ovf_r;
  logic signed [VAL_W-1:0] s4_y_r;
  logic [SPLIT_W-1:0]      s4_lo_r;
  logic [HI_W-1:0]         s4_hi_r;
  logic                    s5_valid_r, s5_neg_r, s5_ovf_r;
  logic signed [VAL_W-1:0] s5_y_r;
  logic [HI_W-1:0]         s5_hi_r;
  logic [LO_W-1:0]         s5_lo_r;
  logic [65:0]             q_full;
  logic                    q_capped;
  logic                    s6_valid_r, s6_neg_r, s6_ovf_r, s6_rem_r;
  logic signed [VAL_W-1:0] s6_y_r;
  logic [Q_W-1:0]          s6_q_r;

  // Final add and output
  logic [RES_W-1:0] opnd;
  logic [RES_W-1:0] res_w;
  logic             res_ok;
  out_item_t        out_nxt;
  out_item_t        out_r;
  logic             out_valid_r;

  // Pipeline moves unless a finished result would overwrite a waiting one
  assign advance      = !(s6_valid_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready  = advance;
  assign in_fire      = in_ch.valid && advance;
  assign cfg_ch.ready = 1'b1;
  assign in_range     = (32'(in_ch.payload.row_index) < 32'(MAX_ROWS));
  assign in_addr      = AW'(in_ch.payload.row_index);

  // Alpha register and its magnitude
  assign alpha_mag_nxt = cfg_ch.payload[VAL_W-1] ? (~cfg_ch.payload + 32'd1)
                                                 : cfg_ch.payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RESET;
      alpha_mag_r <= ALPHA_RESET;
    end else if (cfg_ch.valid) begin
      alpha_r     <= cfg_ch.payload;
      alpha_mag_r <= alpha_mag_nxt;
    end
  end

  // x store: write on a load transfer, read every advancing cycle
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.payload.command == CMD_LOAD && in_range) begin
      mem[in_addr] <= in_ch.payload.value;
    end
    if (advance) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // Product of matrix element and stored x
  assign x_op  = s1_hit_r ? $signed(rd_data_r) : '0;
  assign mul_p = s1_value_r * x_op;

  // Saturating accumulate; finish snapshots then clears
  assign term    = s2_prod_r >>> 16;
  assign sum_w   = {acc_r[ACC_W-1], acc_r} + {term[ACC_W-1], term};
  assign acc_ovf = sum_w[ACC_W] != sum_w[ACC_W-1];
  assign acc_sum = acc_ovf ? (term[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_w[ACC_W-1:0];
  assign acc_mag = acc_r[ACC_W-1] ? (~acc_r + 64'd1) : acc_r;
  assign cm_nxt  = (acc_mag > CM_CLAMP) ? CM_CLAMP[CM_W-1:0] : acc_mag[CM_W-1:0];

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (s2_col_r) begin
      acc_nxt = acc_sum;
      ovf_nxt = ovf_r | acc_ovf;
    end else if (s2_fin_r) begin
      acc_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  // Quotient of the scaled accumulator, capped at 2^33
  assign q_full   = {1'b0, s5_hi_r, 8'b0} + 66'(s5_lo_r[LO_W-1:16]);
  assign q_capped = q_full > Q_CAP;

  // y + t in one adder: negative t is ~q plus one, less the floor remainder
  assign opnd   = s6_neg_r ? ~{2'b00, s6_q_r} : {2'b00, s6_q_r};
  assign res_w  = {{(RES_W-VAL_W){s6_y_r[VAL_W-1]}}, s6_y_r} + opnd
                + RES_W'(s6_neg_r && !s6_rem_r);
  assign res_ok = (res_w[RES_W-1:VAL_W-1] == '0) || (res_w[RES_W-1:VAL_W-1] == '1);

  always_comb begin
    out_nxt.y_result  = s6_y_r;
    out_nxt.saturated = s6_ovf_r;
    if (alpha_r != '0) begin
      if (res_ok) begin
        out_nxt.y_result = res_w[VAL_W-1:0];
      end else begin
        out_nxt.y_result  = res_w[RES_W-1] ? VAL_MIN : VAL_MAX;
        out_nxt.saturated = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_col_r    <= 1'b0;
      s1_fin_r    <= 1'b0;
      s2_col_r    <= 1'b0;
      s2_fin_r    <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_col_r   <= in_fire && in_ch.payload.command == CMD_COLUMN;
        s1_fin_r   <= in_fire && in_ch.payload.command == CMD_FINISH;
        s2_col_r   <= s1_col_r;
        s2_fin_r   <= s1_fin_r;
        s3_valid_r <= s2_fin_r;
        s4_valid_r <= s3_valid_r;
        s5_valid_r <= s4_valid_r;
        s6_valid_r <= s5_valid_r;
        acc_r      <= acc_nxt;
        ovf_r      <= ovf_nxt;
      end
      if (advance && s6_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_value_r <= in_ch.payload.value;
      s1_hit_r   <= in_range;
      s2_y_r     <= s1_value_r;
      s2_prod_r  <= mul_p;
      s3_y_r     <= s2_y_r;
      s3_neg_r   <= alpha_r[VAL_W-1] != acc_r[ACC_W-1];
      s3_ovf_r   <= ovf_r;
      s3_cm_r    <= cm_nxt;
      s4_y_r     <= s3_y_r;
      s4_neg_r   <= s3_neg_r;
      s4_ovf_r   <= s3_ovf_r;
      s4_lo_r    <= s3_cm_r[SPLIT_W-1:0];
      s4_hi_r    <= s3_cm_r[CM_W-1:SPLIT_W] * alpha_mag_r;
      s5_y_r     <= s4_y_r;
      s5_neg_r   <= s4_neg_r;
      s5_ovf_r   <= s4_ovf_r;
      s5_hi_r    <= s4_hi_r;
      s5_lo_r    <= s4_lo_r * alpha_mag_r;
      s6_y_r     <= s5_y_r;
      s6_neg_r   <= s5_neg_r;
      s6_ovf_r   <= s5_ovf_r;
      s6_q_r     <= q_capped ? Q_CAP[Q_W-1:0] : q_full[Q_W-1:0];
      s6_rem_r   <= (s5_lo_r[15:0] != '0) && !q_capped;
    end
    if (advance && s6_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // A finish leaves the accumulator and overflow flag clear
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_fin_r) |=> (acc_r == '0) && !ovf_r)
    else $error("accumulator not cleared after finish");

  // A new result only appears from a finish in the last stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s6_valid_r) && $past(advance))
    else $error("result without a finish in the last stage");

  // A blocked last stage holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s6_valid_r && !advance) |=> s6_valid_r && $stable(s6_y_r) && $stable(s6_q_r))
    else $error("last stage changed while stalled");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tmv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // dropped by the block
  localparam int ROWS             = 1024;
  localparam int RAND_PER_PHASE   = 200;
  localparam int CLAMP_TERMS      = 8;              // 2^46 terms, well past the 2^48 clamp
  localparam int NO_IDLE_PROGRAMS = 16;
  localparam int SETTLE_CYCLES    = 10;
  localparam int DRAIN_LIMIT      = 5000;

  logic clk;
  logic rst_n;

  tmv_chan_if #(.payload_t(in_item_t))  in_ch ();
  tmv_chan_if #(.payload_t(out_item_t)) out_ch ();
  tmv_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();

  transposed_matrix_vector_mac dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted block state
  logic signed [VAL_W-1:0] x_mem [ROWS];
  bit                      x_loaded [ROWS];
  logic [ROW_W-1:0]        written_rows [$];
  logic signed [ACC_W-1:0] acc_q;
  bit                      acc_overflow;
  cfg_word_t               alpha_q;

  out_item_t y_expected [$];
  out_item_t y_want;
  int        mismatches;
  int        item_count;
  bit        tx_gaps_on;
  bit        rx_stall_on;
  int        hold_request;
  int        hold_left;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(rx_stall_on && $urandom_range(99) < 20);
      end
    end
  end

  // Result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (y_expected.size() == 0) begin
        $error("unexpected result: y_result %0d saturated %0d",
               out_ch.payload.y_result, out_ch.payload.saturated);
        mismatches++;
      end else begin
        y_want = y_expected.pop_front();
        if (out_ch.payload.y_result !== y_want.y_result) begin
          $error("y_result mismatch: expected %0d, actual %0d",
                 y_want.y_result, out_ch.payload.y_result);
          mismatches++;
        end
        if (out_ch.payload.saturated !== y_want.saturated) begin
          $error("saturated mismatch: expected %0d, actual %0d",
                 y_want.saturated, out_ch.payload.saturated);
          mismatches++;
        end
      end
    end
  end

  // floor(alpha * acc / 2^16), magnitude capped at 2^33, added to old y
  function automatic out_item_t finish_column(logic signed [VAL_W-1:0] y_old);
    logic [63:0]             acc_mag;
    logic [31:0]             alpha_mag;
    logic [95:0]             full_prod;
    logic [79:0]             quot;
    logic signed [63:0]      scaled;
    logic signed [63:0]      y_sum;
    bit                      frac, negative;
    out_item_t               res;
    res.saturated = acc_overflow;
    y_sum = {{32{y_old[31]}}, y_old};
    if (alpha_q != 0) begin
      negative  = alpha_q[31] != acc_q[63];
      alpha_mag = alpha_q[31] ? -alpha_q : alpha_q;
      acc_mag   = acc_q[63] ? -acc_q : acc_q;
      if (acc_mag > (64'd1 << 48))
        acc_mag = 64'd1 << 48;
      full_prod = acc_mag * alpha_mag;
      quot      = full_prod >> 16;
      frac      = |full_prod[15:0];
      if (quot > (80'd1 << 33)) begin
        quot = 80'd1 << 33;
        frac = 1'b0;
      end
      scaled = $signed({30'd0, quot[33:0]});
      if (negative)
        scaled = -scaled - (frac ? 64'sd1 : 64'sd0);
      y_sum = y_sum + scaled;
      if (y_sum > 64'sh0000_0000_7FFF_FFFF) begin
        y_sum = 64'sh0000_0000_7FFF_FFFF;
        res.saturated = 1'b1;
      end else if (y_sum < 64'shFFFF_FFFF_8000_0000) begin
        y_sum = 64'shFFFF_FFFF_8000_0000;
        res.saturated = 1'b1;
      end
    end
    res.y_result = y_sum[31:0];
    return res;
  endfunction

  // Update predicted state for one accepted item
  function automatic void apply_item(in_item_t it);
    logic signed [63:0] prod;
    logic signed [63:0] term;
    logic [64:0]        sum;
    case (it.command)
      CMD_LOAD: begin
        x_mem[it.row_index] = it.value;
        if (!x_loaded[it.row_index]) begin
          x_loaded[it.row_index] = 1'b1;
          written_rows.push_back(it.row_index);
        end
      end
      CMD_COLUMN: begin
        prod = $signed({{32{it.value[31]}}, it.value})
             * $signed({{32{x_mem[it.row_index][31]}}, x_mem[it.row_index]});
        term = prod >>> 16;
        sum  = {acc_q[63], acc_q} + {term[63], term};
        if (sum[64] != sum[63]) begin
          acc_q        = term[63] ? ACC_MIN : ACC_MAX;
          acc_overflow = 1'b1;
        end else begin
          acc_q = sum[63:0];
        end
      end
      CMD_FINISH: begin
        y_expected.push_back(finish_column(it.value));
        acc_q        = '0;
        acc_overflow = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // One input transfer, with random gaps before it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                           logic signed [VAL_W-1:0] val);
    in_item_t it;
    it.command   = cmd;
    it.row_index = row;
    it.value     = val;
    @(negedge clk);
    while (tx_gaps_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_item(it);
    if (cmd != CMD_UNUSED)
      item_count++;
  endtask

  // Drop valid, wait for outstanding results, then let the pipe settle
  task automatic wait_idle();
    int waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (y_expected.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (y_expected.size() > 0) begin
      $error("%0d results never arrived", y_expected.size());
      mismatches++;
      y_expected.delete();
    end
  endtask

  task automatic write_alpha(cfg_word_t alpha);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= alpha;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    alpha_q = alpha;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mix of full-range, small, extreme and unit values
  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4, 5, 6: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(1)) v = -v;
      end
      7: begin
        case ($urandom_range(3))
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      default: v = $urandom_range(1) ? 32'sh0001_0000 : -32'sh0001_0000;
    endcase
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] pick_loaded_row();
    return written_rows[$urandom_range(0, written_rows.size() - 1)];
  endfunction

  // Loads, a run of matrix elements over loaded rows, then a finish
  task automatic send_column_program();
    int n_loads;
    int n_terms;
    n_loads = $urandom_range(0, 4);
    if (written_rows.size() == 0)
      n_loads = 1;
    repeat (n_loads) send_item(CMD_LOAD, ROW_W'($urandom), rand_value());
    n_terms = $urandom_range(1, 8);
    repeat (n_terms) send_item(CMD_COLUMN, pick_loaded_row(), rand_value());
    send_item(CMD_FINISH, ROW_W'($urandom), rand_value());
  endtask

  // Field extremes, rounding toward minus infinity, result clamping
  task automatic test_directed();
    send_item(CMD_LOAD, 10'd0, VAL_MAX);
    send_item(CMD_LOAD, 10'd1023, VAL_MIN);
    send_item(CMD_LOAD, 10'd1, 32'sh0001_0000);
    send_item(CMD_LOAD, 10'd2, -32'sd1);
    send_item(CMD_UNUSED, 10'd1023, -32'sd1);
    send_item(CMD_FINISH, 10'd0, VAL_MIN);
    send_item(CMD_COLUMN, 10'd1, 32'sh0002_0000);
    send_item(CMD_FINISH, 10'd0, 32'sh0001_0000);
    send_item(CMD_COLUMN, 10'd2, 32'sd1);
    send_item(CMD_FINISH, 10'd0, 32'sd0);
    send_item(CMD_COLUMN, 10'd0, VAL_MAX);
    send_item(CMD_COLUMN, 10'd1023, VAL_MIN);
    send_item(CMD_FINISH, 10'd1023, VAL_MAX);
    send_item(CMD_COLUMN, 10'd0, VAL_MIN);
    send_item(CMD_FINISH, 10'd0, VAL_MIN);
    send_item(CMD_LOAD, 10'd0, 32'sd1);
    send_item(CMD_COLUMN, 10'd0, 32'sd1);
    send_item(CMD_COLUMN, 10'd1, VAL_MIN);
    send_item(CMD_FINISH, 10'h3FF, 32'sd0);
  endtask

  // Random traffic over several alpha settings, extremes included
  task automatic test_random_phases();
    cfg_word_t alphas [7];
    int        start;
    int        pick;
    alphas = '{32'sh0001_0000, 32'sh0000_0000, VAL_MAX, VAL_MIN,
               32'shFFFF_0000, 32'sh0000_8000, 32'sh0000_0000};
    alphas[6] = $urandom;
    foreach (alphas[p]) begin
      write_alpha(alphas[p]);
      start = item_count;
      while (item_count - start < RAND_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 80)
          send_column_program();
        else if (pick < 90)
          send_item(CMD_UNUSED, ROW_W'($urandom), $urandom);
        else if (pick < 95)
          send_item(CMD_FINISH, ROW_W'($urandom), rand_value());
        else
          send_item(CMD_LOAD, ROW_W'($urandom), rand_value());
      end
    end
  endtask

  // Receiver holds off while finishes keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_alpha(32'sh0000_4000);
    tx_gaps_on   = 1'b0;
    hold_request = 200;
    repeat (40) begin
      send_item(CMD_COLUMN, pick_loaded_row(), rand_value());
      send_item(CMD_FINISH, ROW_W'($urandom), rand_value());
    end
    tx_gaps_on = 1'b1;
  endtask

  // Drive the accumulator past the scaling clamp, again with alpha zero,
  // then a burst of traffic with neither side idling
  task automatic test_accumulator_clamp();
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    write_alpha(32'sh0001_0000);
    send_item(CMD_LOAD, 10'd7, VAL_MIN);
    repeat (CLAMP_TERMS) send_item(CMD_COLUMN, 10'd7, VAL_MIN);
    send_item(CMD_FINISH, 10'd7, 32'sd0);
    write_alpha(32'sh0000_0000);
    repeat (CLAMP_TERMS) send_item(CMD_COLUMN, 10'd7, VAL_MAX);
    send_item(CMD_FINISH, 10'd7, rand_value());
    write_alpha(32'sh0001_0000);
    repeat (NO_IDLE_PROGRAMS) send_column_program();
    wait_idle();
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    acc_q          = '0;
    acc_overflow   = 1'b0;
    alpha_q        = ALPHA_RESET;
    mismatches     = 0;
    item_count     = 0;
    tx_gaps_on     = 1'b1;
    rx_stall_on    = 1'b1;
    hold_request   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phases();
    test_output_backpressure();
    test_accumulator_clamp();
    wait_idle();

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
